[hw/rtl/lcdi2c_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lcdi2c_pkg;

  localparam int MAX_COLUMNS = 40;
  localparam int MAX_ROWS    = 4;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 2;
  localparam int RCFG_W = 3;
  localparam int CFG_W  = 6;

  // Input op codes; code 3 carries no meaning and is dropped.
  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_POS  = 2'd1;
  localparam logic [1:0] OP_CMD  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BACKLIGHT = 2'd0;
  localparam logic [1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // LCD byte queue between the front and back ends.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } lcd_entry_t;

  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/char_lcd_text_to_i2c_expander_bytes.sv]
// Turns text characters, cursor-position requests and raw LCD commands into
// the byte stream for an I2C port expander driving an HD44780-style display
// in 4-bit mode (bit 0 RS, bit 2 EN, bit 3 backlight, bits 7..4 nibble).
// Each LCD byte becomes four expander beats; a plain character, a command or
// a position request gives 4 beats, a character that wraps the line first
// gives 8. The result side delivers one beat per cycle while pop is held, and
// the output serializer sets the sustained rate. The input side takes a new
// item in any cycle the 4-entry LCD byte queue has room for two entries, so
// items are taken while earlier ones are still being sent.
// Op code 3 is accepted and dropped. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_text_to_i2c_expander_bytes (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] op,
  input  wire logic [7:0] value,
  input  wire logic [5:0] target_column,
  input  wire logic [1:0] target_row,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      expander_byte,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);
  import lcdi2c_pkg::*;

  logic              backlight_on;
  logic [COL_W-1:0]  columns_in_use;
  logic [RCFG_W-1:0] rows_in_use;
  logic              accept;
  logic [1:0]        wr_num;
  lcd_entry_t        wr_entry0;
  lcd_entry_t        wr_entry1;
  logic              room_for_two;
  logic              q_valid;
  lcd_entry_t        q_entry;
  logic              q_pop;
  logic              out_valid;

  assign cfg_ready = 1'b1;
  assign full      = !room_for_two;
  assign accept    = push && !full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on   <= 1'b1;
      columns_in_use <= COL_W'(16);
      rows_in_use    <= RCFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BACKLIGHT: backlight_on   <= cfg_data[0];
        CFG_COLUMNS:   columns_in_use <= cfg_data;
        CFG_ROWS:      rows_in_use    <= cfg_data[RCFG_W-1:0];
        default: ;
      endcase
    end
  end

  lcdi2c_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .op             (op),
    .value          (value),
    .target_column  (target_column),
    .target_row     (target_row),
    .columns_in_use (columns_in_use),
    .rows_in_use    (rows_in_use),
    .wr_num         (wr_num),
    .wr_entry0      (wr_entry0),
    .wr_entry1      (wr_entry1)
  );

  lcdi2c_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .wr_num       (wr_num),
    .wr_entry0    (wr_entry0),
    .wr_entry1    (wr_entry1),
    .room_for_two (room_for_two),
    .rd_valid     (q_valid),
    .rd_entry     (q_entry),
    .rd_pop       (q_pop)
  );

  lcdi2c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .backlight_on (backlight_on),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_byte     (expander_byte),
    .out_last     (last_of_run),
    .out_take     (pop)
  );

endmodule
`default_nettype wire

[hw/rtl/lcdi2c_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module lcdi2c_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic [1:0]              op,
  input  wire logic [7:0]              value,
  input  wire logic [5:0]              target_column,
  input  wire logic [1:0]              target_row,
  input  wire logic [5:0]              columns_in_use,
  input  wire logic [2:0]              rows_in_use,
  output logic [1:0]                   wr_num,
  output lcdi2c_pkg::lcd_entry_t       wr_entry0,
  output lcdi2c_pkg::lcd_entry_t       wr_entry1
);
  import lcdi2c_pkg::*;

  logic [COL_W-1:0]  cursor_column, cursor_column_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [COL_W-1:0]  eff_cols;
  logic [RCFG_W-1:0] eff_rows;
  logic [1:0]        num;

  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
                                                input logic [RCFG_W-1:0] rows);
    logic [RCFG_W-1:0] inc;
    inc = {1'b0, r} + RCFG_W'(1);
    return (inc >= rows) ? '0 : inc[ROW_W-1:0];
  endfunction

  function automatic lcd_entry_t addr_entry(input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row);
    lcd_entry_t e;
    e.data    = CMD_SET_ADDR | ({2'b00, col} + row_base(row));
    e.is_data = 1'b0;
    e.last    = 1'b0;
    return e;
  endfunction

  always_comb begin
    if (columns_in_use == '0) eff_cols = COL_W'(1);
    else if (columns_in_use > COL_W'(MAX_COLUMNS)) eff_cols = COL_W'(MAX_COLUMNS);
    else eff_cols = columns_in_use;
    if (rows_in_use == '0) eff_rows = RCFG_W'(1);
    else if (rows_in_use > RCFG_W'(MAX_ROWS)) eff_rows = RCFG_W'(MAX_ROWS);
    else eff_rows = rows_in_use;
  end

  always_comb begin
    logic              wrap;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  cr_row;
    logic [ROW_W-1:0]  pos_row;
    lcd_entry_t        wrap_ent;
    lcd_entry_t        main_ent;

    num                = 2'd0;
    wr_entry0          = '0;
    wr_entry1          = '0;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    wrap               = cursor_column >= eff_cols;
    cur_col            = wrap ? '0 : cursor_column;
    cur_row            = wrap ? next_row(cursor_row, eff_rows) : cursor_row;
    // A row left past the rows in use drops to row 0 on a carriage return.
    cr_row             = ({1'b0, cur_row} >= eff_rows) ? '0 : cur_row;
    wrap_ent           = addr_entry('0, cur_row);
    main_ent           = '0;
    pos_row            = ({1'b0, target_row} >= eff_rows) ? '0 : target_row;

    case (op)
      OP_TEXT: begin
        if (value == CH_LF) begin
          main_ent           = addr_entry(cur_col, next_row(cur_row, eff_rows));
          cursor_column_next = cur_col;
          cursor_row_next    = next_row(cur_row, eff_rows);
        end else if (value == CH_CR) begin
          main_ent           = addr_entry('0, cr_row);
          cursor_column_next = '0;
          cursor_row_next    = cr_row;
        end else begin
          main_ent.data      = value;
          main_ent.is_data   = 1'b1;
          main_ent.last      = 1'b0;
          cursor_column_next = cur_col + COL_W'(1);
          cursor_row_next    = cur_row;
        end
        main_ent.last = 1'b1;
        if (wrap) begin
          num       = 2'd2;
          wr_entry0 = wrap_ent;
          wr_entry1 = main_ent;
        end else begin
          num       = 2'd1;
          wr_entry0 = main_ent;
        end
      end
      OP_POS: begin
        num                = 2'd1;
        wr_entry0          = addr_entry(target_column, pos_row);
        wr_entry0.last     = 1'b1;
        cursor_column_next = target_column;
        cursor_row_next    = pos_row;
      end
      OP_CMD: begin
        num               = 2'd1;
        wr_entry0.data    = value;
        wr_entry0.is_data = 1'b0;
        wr_entry0.last    = 1'b1;
      end
      default: begin
        num = 2'd0;
      end
    endcase
  end

  assign wr_num = accept ? num : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lcdi2c_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module lcdi2c_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [1:0]              wr_num,
  input  wire lcdi2c_pkg::lcd_entry_t  wr_entry0,
  input  wire lcdi2c_pkg::lcd_entry_t  wr_entry1,
  output logic                         room_for_two,
  output logic                         rd_valid,
  output lcdi2c_pkg::lcd_entry_t       rd_entry,
  input  wire logic                    rd_pop
);
  import lcdi2c_pkg::*;

  lcd_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign room_for_two = count <= QCNT_W'(QDEPTH - 2);
  assign rd_valid     = count != '0;
  assign rd_entry     = slots[rptr];
  assign do_pop       = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_num != 2'd0) slots[wptr] <= wr_entry0;
    if (wr_num == 2'd2) slots[wptr + QPTR_W'(1)] <= wr_entry1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(wr_num);
      if (do_pop) rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(wr_num) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lcdi2c_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module lcdi2c_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    backlight_on,
  input  wire logic                    q_valid,
  input  wire lcdi2c_pkg::lcd_entry_t  q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  input  wire logic                    out_take
);
  import lcdi2c_pkg::*;

  logic [1:0] phase;
  logic       advance;
  logic [3:0] nibble;
  logic [7:0] byte_next;

  // Phase 0/1: high nibble with/without EN; phase 2/3: low nibble.
  assign advance   = !out_valid || out_take;
  assign q_pop     = advance && q_valid && (phase == 2'd3);
  assign nibble    = phase[1] ? q_entry.data[3:0] : q_entry.data[7:4];
  assign byte_next = {nibble, backlight_on, !phase[0], 1'b0, q_entry.is_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid;
      if (q_valid) phase <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      out_byte <= byte_next;
      out_last <= q_entry.last && (phase == 2'd3);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lcdi2c_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module lcdi2c_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] expander_byte,
  input wire logic       last_of_run
);

  logic out_beat;
  assign out_beat = !empty && pop;

  // Nothing waits on the result side right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(expander_byte) && $stable(last_of_run)))
    else $error("stalled result beat changed");

  // An EN-high beat is followed at once by the same nibble with EN low.
  a_strobe_pair: assert property (@(posedge clk) disable iff (rst)
    (out_beat && expander_byte[2]) |=>
      (!empty && !expander_byte[2] && expander_byte[7:4] == $past(expander_byte[7:4])))
    else $error("enable strobe not followed by its release beat");

  a_last_no_en: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_run) |-> (!expander_byte[2] && !expander_byte[1]))
    else $error("run ends on a beat with enable high");

endmodule

bind char_lcd_text_to_i2c_expander_bytes lcdi2c_checker u_lcdi2c_checker (.*);
`default_nettype wire
